// ===== src/kbms_pkg.sv =====
// kbms_pkg: shared types and constants of the key matrix event scanner
// used by the scanner top level
`default_nettype none

package kbms_pkg;

    // request kinds
    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // modifier key positions in the matrix
    localparam logic [5:0] POS_LSHIFT = 6'd15;
    localparam logic [5:0] POS_RSHIFT = 6'd52;
    localparam logic [5:0] POS_CTRL   = 6'd58;
    localparam logic [5:0] POS_CMDR   = 6'd61;

    localparam logic [7:0] NO_EVENT  = 8'hff;
    localparam logic [5:0] CODE_LAST = 6'd63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP
    } t_state;

endpackage

`default_nettype wire

// ===== src/kbms_if.sv =====
// kbms request and response channels, valid/ready handshake
// no dependencies
`default_nettype none

interface kbms_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] pressed_matrix;
    logic [5:0]  key_code;

    modport source (output valid, kind, pressed_matrix, key_code, input ready);
    modport sink   (input valid, kind, pressed_matrix, key_code, output ready);
endinterface

interface kbms_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] event_code;
    logic       key_down;
    logic [3:0] modifiers;
    logic [3:0] pending_events;

    modport source (output valid, event_code, key_down, modifiers, pending_events,
                    input ready);
    modport sink   (input valid, event_code, key_down, modifiers, pending_events,
                    output ready);
endinterface

`default_nettype wire

// ===== src/keyboard_matrix_event_scanner.sv =====
// keyboard_matrix_event_scanner: a scan request compares all 64 keys, one key per cycle
// by the single bit-compare/push step; a pop goes through a registered stack read; query and
// unused kinds answer from idle; the result then sits in the output register until taken
// one request at a time; the next request is taken once the block is idle and the output
// register is empty or being drained; synchronous active-low reset clears snapshot, count,
// modifiers, sequencer and output valid; stack contents are not cleared
`default_nettype none

module keyboard_matrix_event_scanner #(
    parameter int EVENT_DEPTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    kbms_req_if.sink    i_req,
    kbms_rsp_if.source  o_rsp
);

    // count must hold the depth itself, address only the entries
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;

    // sequencer and control state
    kbms_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [5:0]       r_code, n_code;
    logic             r_out_valid, n_out_valid;

    // key state: stored snapshot rotates through bit 0 while the new snapshot shifts in
    logic [63:0]      r_last, n_last;
    logic [63:0]      r_shift, n_shift;
    logic [3:0]       r_mods, n_mods;

    // output payload register
    logic [7:0]       r_out_ev, n_out_ev;
    logic             r_out_down, n_out_down;
    logic [3:0]       r_out_mods;
    logic [3:0]       r_out_pend;

    // event stack memory
    logic [6:0]       r_stack [EVENT_DEPTH];
    logic [6:0]       r_rd_data;

    logic             in_ready;
    logic             accept;
    logic             load_out;
    logic             wr_en;
    logic             rd_en;
    logic [6:0]       wr_data;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    cnt_dec;
    logic             has_room;
    logic             key_changed;

    assign in_ready = (r_state == kbms_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept   = i_req.valid && in_ready;

    // shared step unit: one count compare and one bit compare per cycle
    assign has_room    = (r_count < CW'(EVENT_DEPTH));
    assign key_changed = r_shift[0] ^ r_last[0];
    assign cnt_dec     = r_count - CW'(1);
    assign wr_addr     = r_count[AW-1:0];
    assign rd_addr     = cnt_dec[AW-1:0];
    // press pushes the code, release sets the 0x40 flag
    assign wr_data     = {~r_shift[0], r_code};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kbms_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_req.kind == kbms_pkg::KIND_SCAN) begin
                        n_state = kbms_pkg::ST_SCAN;
                    end else if (i_req.kind == kbms_pkg::KIND_POP && r_count != '0) begin
                        n_state = kbms_pkg::ST_POP;
                    end
                end
            end
            kbms_pkg::ST_SCAN: begin
                if (r_code == kbms_pkg::CODE_LAST) begin
                    n_state = kbms_pkg::ST_IDLE;
                end
            end
            kbms_pkg::ST_POP: begin
                n_state = kbms_pkg::ST_IDLE;
            end
            default: begin
                n_state = kbms_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count    = r_count;
        n_code     = r_code;
        n_shift    = r_shift;
        n_last     = r_last;
        n_mods     = r_mods;
        n_out_ev   = kbms_pkg::NO_EVENT;
        n_out_down = 1'b0;
        load_out   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (r_state)
            kbms_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        kbms_pkg::KIND_SCAN: begin
                            n_shift = i_req.pressed_matrix;
                            n_code  = '0;
                        end
                        kbms_pkg::KIND_POP: begin
                            if (r_count != '0) begin
                                n_count = cnt_dec;
                                rd_en   = 1'b1;
                            end else begin
                                // empty stack answers at once with no event
                                load_out = 1'b1;
                            end
                        end
                        kbms_pkg::KIND_QUERY: begin
                            n_out_down = r_last[i_req.key_code];
                            load_out   = 1'b1;
                        end
                        default: begin
                            // unused kind: plain status result
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            kbms_pkg::ST_SCAN: begin
                if (key_changed && has_room) begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
                n_last  = {r_shift[0], r_last[63:1]};
                n_shift = {1'b0, r_shift[63:1]};
                n_code  = r_code + 6'd1;
                if (r_code == kbms_pkg::CODE_LAST) begin
                    // after 64 rotations the stored snapshot is the new one
                    n_mods   = {n_last[kbms_pkg::POS_CMDR], n_last[kbms_pkg::POS_CTRL],
                                n_last[kbms_pkg::POS_RSHIFT], n_last[kbms_pkg::POS_LSHIFT]};
                    load_out = 1'b1;
                end
            end
            kbms_pkg::ST_POP: begin
                n_out_ev = {1'b0, r_rd_data};
                load_out = 1'b1;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
        n_out_valid = load_out ? 1'b1 : (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kbms_pkg::ST_IDLE;
            r_count     <= '0;
            r_code      <= '0;
            r_last      <= '0;
            r_mods      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_code      <= n_code;
            r_last      <= n_last;
            r_mods      <= n_mods;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        if (load_out) begin
            r_out_ev   <= n_out_ev;
            r_out_down <= n_out_down;
            r_out_mods <= n_mods;
            r_out_pend <= 4'(n_count);
        end
    end

    // event stack: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_stack[rd_addr];
        end
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.event_code     = r_out_ev;
    assign o_rsp.key_down       = r_out_down;
    assign o_rsp.modifiers      = r_out_mods;
    assign o_rsp.pending_events = r_out_pend;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(EVENT_DEPTH))
        else $error("event count above stack depth");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kbms_pkg::ST_IDLE) |-> !i_req.ready)
        else $error("request taken while sequencer busy");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.kind == kbms_pkg::KIND_SCAN)
            |=> (r_state == kbms_pkg::ST_SCAN && r_code == 6'd0))
        else $error("scan did not start at key zero");

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kbms_pkg::ST_SCAN && r_code == kbms_pkg::CODE_LAST)
            |=> (r_out_valid && r_state == kbms_pkg::ST_IDLE))
        else $error("scan end did not post a result");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.kind == kbms_pkg::KIND_POP && r_count != '0)
            |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not decrement count");
`endif

endmodule

`default_nettype wire
